// ===== hdl/jsu_pkg.sv =====
package jsu_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] BAD_HEX   = 8'hFF;

  localparam logic [15:0] HIGH_MIN = 16'hD800;
  localparam logic [15:0] HIGH_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // One input item after classification: an optional code point, then up to
  // three literal bytes, then the end flag.
  typedef struct packed {
    logic            cp_en;
    logic [20:0]     cp;
    logic [1:0]      txt_n;
    logic [2:0][7:0] txt;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } utf8_t;

  function automatic logic [7:0] map_escape(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      CH_B:    r = 8'h08;
      CH_F:    r = 8'h0C;
      CH_N:    r = 8'h0A;
      CH_R:    r = 8'h0D;
      CH_T:    r = 8'h09;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r.b = '0;
    if (cp < 21'h80) begin
      r.n    = 3'd1;
      r.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      r.n    = 3'd2;
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      r.n    = 3'd3;
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
    end else begin
      r.n    = 3'd4;
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

// ===== hdl/jsu_in_if.sv =====
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

// ===== hdl/jsu_out_if.sv =====
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_done;

  modport source (output valid, output out_byte, output byte_valid, output string_done,
                  input ready);
  modport sink (input valid, input out_byte, input byte_valid, input string_done,
                output ready);
endinterface

// ===== hdl/jsu_front.sv =====
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output logic          push_o,
  output jsu_pkg::cmd_t cmd_o
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    M_PLAIN      = 3'd0,
    M_ESC        = 3'd1,
    M_HEX1       = 3'd2,
    M_AFTER_HIGH = 3'd3,
    M_HIGH_BS    = 3'd4,
    M_HEX2       = 3'd5
  } mode_e;

  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][7:0] b;
  } txt_t;

  mode_e           mode_q, mode_d;
  logic [15:0]     hex_q, hex_d;
  logic            inv_q, inv_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [15:0]     pend_q, pend_d;
  logic [2:0][7:0] held_q;
  logic            held_we;
  logic            hex_ok;
  logic [3:0]      digit;
  logic [15:0]     hex_new;
  logic            inv_new;
  logic [2:0][7:0] replay_src;
  txt_t            replay_txt;
  cmd_t            cmd;

  function automatic txt_t replay(input logic [2:0][7:0] h, input logic [1:0] cnt);
    txt_t r;
    logic esc;
    r   = '0;
    esc = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) <= cnt) begin
        if (esc) begin
          esc = 1'b0;
          if (h[i] != CH_U) begin
            r.b[r.n] = map_escape(h[i]);
            r.n      = r.n + 2'd1;
          end
        end else if (h[i] == CH_BSLASH) begin
          esc = 1'b1;
        end else begin
          r.b[r.n] = h[i];
          r.n      = r.n + 2'd1;
        end
      end
    end
    return r;
  endfunction

  always_comb begin
    hex_ok = 1'b1;
    digit  = 4'd0;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      digit = byte_i[3:0];
    end else if ((byte_i >= 8'h61 && byte_i <= 8'h66) ||
                 (byte_i >= 8'h41 && byte_i <= 8'h46)) begin
      digit = byte_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
    hex_new = {hex_q[11:0], digit};
    inv_new = inv_q | ~hex_ok;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      replay_src[i] = (2'(i) == cnt_q) ? byte_i : held_q[i];
    end
    replay_txt = replay(replay_src, cnt_q);
  end

  always_comb begin
    mode_d  = mode_q;
    hex_d   = hex_q;
    inv_d   = inv_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    held_we = 1'b0;
    cmd     = '0;
    cmd.last = last_i;

    unique case (mode_q)
      M_ESC: begin
        if (byte_i == CH_U) begin
          if (!last_i) begin
            mode_d = M_HEX1;
            hex_d  = '0;
            inv_d  = 1'b0;
            cnt_d  = '0;
          end
        end else begin
          cmd.txt[0] = map_escape(byte_i);
          cmd.txt_n  = 2'd1;
          mode_d     = M_PLAIN;
        end
      end
      M_HEX1, M_HEX2: begin
        hex_d = hex_new;
        inv_d = inv_new;
        if (cnt_q != 2'd3) begin
          held_we = 1'b1;
          cnt_d   = cnt_q + 2'd1;
          if (last_i) begin
            cmd.cp_en = (mode_q == M_HEX2);
            cmd.cp    = {5'd0, pend_q};
            cmd.txt   = replay_txt.b;
            cmd.txt_n = replay_txt.n;
          end
        end else if (mode_q == M_HEX1) begin
          cnt_d  = '0;
          mode_d = M_PLAIN;
          if (inv_new) begin
            cmd.txt[0] = BAD_HEX;
            cmd.txt_n  = 2'd1;
          end else if (hex_new >= HIGH_MIN && hex_new <= HIGH_MAX && !last_i) begin
            pend_d = hex_new;
            mode_d = M_AFTER_HIGH;
          end else begin
            cmd.cp_en = 1'b1;
            cmd.cp    = {5'd0, hex_new};
          end
        end else begin
          cnt_d     = '0;
          mode_d    = M_PLAIN;
          cmd.cp_en = 1'b1;
          if (!inv_new && hex_new >= LOW_MIN && hex_new <= LOW_MAX) begin
            cmd.cp = SUPP_BASE + {1'b0, pend_q[9:0], hex_new[9:0]};
          end else begin
            cmd.cp = {5'd0, pend_q};
          end
        end
      end
      M_AFTER_HIGH: begin
        if (byte_i == CH_BSLASH && !last_i) begin
          mode_d = M_HIGH_BS;
        end else begin
          cmd.cp_en = 1'b1;
          cmd.cp    = {5'd0, pend_q};
          if (byte_i != CH_BSLASH) begin
            cmd.txt[0] = byte_i;
            cmd.txt_n  = 2'd1;
          end
          mode_d = M_PLAIN;
        end
      end
      M_HIGH_BS: begin
        if (byte_i == CH_U && !last_i) begin
          mode_d = M_HEX2;
          hex_d  = '0;
          inv_d  = 1'b0;
          cnt_d  = '0;
        end else begin
          cmd.cp_en = 1'b1;
          cmd.cp    = {5'd0, pend_q};
          if (byte_i != CH_U) begin
            cmd.txt[0] = map_escape(byte_i);
            cmd.txt_n  = 2'd1;
          end
          mode_d = M_PLAIN;
        end
      end
      default: begin
        mode_d = M_PLAIN;
        if (byte_i == CH_BSLASH) begin
          if (!last_i) mode_d = M_ESC;
        end else begin
          cmd.txt[0] = byte_i;
          cmd.txt_n  = 2'd1;
        end
      end
    endcase

    if (last_i) begin
      mode_d = M_PLAIN;
      hex_d  = '0;
      inv_d  = 1'b0;
      cnt_d  = '0;
      pend_d = '0;
    end
  end

  // Drop requests that cause no result and do not end the string.
  assign push_o = accept_i && (cmd.cp_en || cmd.txt_n != 2'd0 || cmd.last);
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_PLAIN;
      hex_q  <= '0;
      inv_q  <= 1'b0;
      cnt_q  <= '0;
      pend_q <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      hex_q  <= hex_d;
      inv_q  <= inv_d;
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && held_we) begin
      held_q[cnt_q] <= byte_i;
    end
  end

endmodule

// ===== hdl/jsu_queue.sv =====
module jsu_queue #(
  parameter int unsigned Depth = jsu_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output jsu_pkg::cmd_t cmd_o
);
  import jsu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ===== hdl/jsu_back.sv =====
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  jsu_pkg::cmd_t cmd_i,
  output logic          pop_o,
  jsu_out_if.source     out_o
);
  import jsu_pkg::*;

  utf8_t      enc;
  logic [2:0] n_cp;
  logic [2:0] total;
  logic [2:0] last_idx;
  logic [2:0] idx_q;
  logic [2:0] txt_idx;
  logic [7:0] sel_byte;
  logic       advance;
  logic       load;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       bv_q;
  logic       done_q;

  always_comb begin
    enc      = utf8_encode(cmd_i.cp);
    n_cp     = cmd_i.cp_en ? enc.n : 3'd0;
    total    = n_cp + {1'b0, cmd_i.txt_n};
    // A request with no data still gives one bare end marker.
    last_idx = (total == 3'd0) ? 3'd0 : total - 3'd1;
    txt_idx  = idx_q - n_cp;
    if (idx_q < n_cp) begin
      sel_byte = enc.b[idx_q[1:0]];
    end else begin
      sel_byte = (txt_idx[1:0] == 2'd3) ? 8'd0 : cmd_i.txt[txt_idx[1:0]];
    end
  end

  assign advance = !valid_q || out_o.ready;
  assign load    = advance && valid_i;
  assign pop_o   = load && (idx_q == last_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (advance) begin
      valid_q <= valid_i;
      if (load) begin
        idx_q <= pop_o ? 3'd0 : idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= (total == 3'd0) ? 8'd0 : sel_byte;
      bv_q   <= (total != 3'd0);
      done_q <= cmd_i.last && (idx_q == last_idx);
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.out_byte    = byte_q;
  assign out_o.byte_valid  = bv_q;
  assign out_o.string_done = done_q;

endmodule

// ===== hdl/json_string_unescape_utf8.sv =====
// JSON string unescaper: takes one raw byte of a string body per cycle and
// gives the unescaped bytes, with \uXXXX escapes (and surrogate pairs) written
// as UTF-8. The input side takes a byte every cycle while the command queue
// between the decoder and the output serializer has room; the serializer
// gives one result per cycle while the receiver is ready, and an input byte
// yields 0 to 6 results (a surrogate pair gives 4 at once), so bursts are
// absorbed by the QueueDepth-entry queue. Every last byte of a string yields
// a result with string_done set, a bare one (byte_valid low) when it has no
// data. Each command is stored in the queue, then registered at the output.
module json_string_unescape_utf8 #(
  parameter int unsigned QueueDepth = jsu_pkg::QUEUE_DEPTH
) (
  input logic       clk_i,
  input logic       rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);
  import jsu_pkg::*;

  logic accept;
  logic push;
  logic full;
  logic pop;
  logic q_valid;
  cmd_t front_cmd;
  cmd_t head_cmd;

  assign in_i.ready = !full;
  assign accept     = in_i.valid && !full;

  jsu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_i.in_byte),
    .last_i   (in_i.end_of_string),
    .push_o   (push),
    .cmd_o    (front_cmd)
  );

  jsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  jsu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .cmd_i   (head_cmd),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== tb/sv/json_string_unescape_utf8_tb.sv =====
`timescale 1ns / 1ps

module json_string_unescape_utf8_tb;
  import jsu_pkg::*;

  localparam int N_RAND      = 340;
  localparam int HOLD_CYCLES = 100;
  localparam int MAX_PER_REQ = 6;
  localparam int TIMEOUT_NS  = 5_000_000;

  typedef enum logic [2:0] {
    ST_TEXT,
    ST_ESC,
    ST_HEX1,
    ST_AFTER_HI,
    ST_HI_BSLASH,
    ST_HEX2
  } scan_e;

  typedef struct packed {
    logic [7:0] data;
    logic       data_ok;
    logic       done;
  } uchunk_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    uchunk_t    want;
  } dir_row_t;

  localparam int N_DIR = 28;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{8'h00,     1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{8'hFF,     1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}},
    // trailing backslash: bare end marker
    '{CH_BSLASH, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
    '{CH_BSLASH, 1'b0, 1'b0, '0},
    '{CH_T,      1'b1, 1'b1, '{8'h09, 1'b1, 1'b1}},
    // bad hex digits collapse to one error byte
    '{CH_BSLASH, 1'b0, 1'b0, '0},
    '{CH_U,      1'b0, 1'b0, '0},
    '{"Z",       1'b0, 1'b0, '0},
    '{"z",       1'b0, 1'b0, '0},
    '{"9",       1'b0, 1'b0, '0},
    '{"Q",       1'b1, 1'b1, '{BAD_HEX, 1'b1, 1'b1}},
    // surrogate pair, four bytes from the last digit
    '{CH_BSLASH, 1'b0, 1'b0, '0},
    '{CH_U,      1'b0, 1'b0, '0},
    '{"d",       1'b0, 1'b0, '0},
    '{"8",       1'b0, 1'b0, '0},
    '{"3",       1'b0, 1'b0, '0},
    '{"D",       1'b0, 1'b0, '0},
    '{CH_BSLASH, 1'b0, 1'b0, '0},
    '{CH_U,      1'b0, 1'b0, '0},
    '{"D",       1'b0, 1'b0, '0},
    '{"e",       1'b0, 1'b0, '0},
    '{"0",       1'b0, 1'b0, '0},
    '{"0",       1'b1, 1'b0, '0},
    // \u cut off after one digit: digit comes back as text
    '{CH_BSLASH, 1'b0, 1'b0, '0},
    '{CH_U,      1'b0, 1'b0, '0},
    '{"4",       1'b1, 1'b1, '{8'h34, 1'b1, 1'b1}},
    '{CH_BSLASH, 1'b0, 1'b0, '0},
    '{CH_U,      1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  jsu_in_if  req_if ();
  jsu_out_if res_if ();

  json_string_unescape_utf8 DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // unescaper state
  scan_e       st;
  logic [15:0] acc;
  logic        acc_bad;
  logic [2:0]  ndig;
  logic [7:0]  held [3];
  logic [15:0] hi_sur;
  uchunk_t     step_out [MAX_PER_REQ];
  int          step_n;

  uchunk_t     unescaped_q [$];
  logic [7:0]  str_q [$];

  bit quiet    = 1'b0;
  bit hold_req = 1'b0;
  int n_err    = 0;
  int n_res    = 0;
  int n_str    = 0;
  int n_rand   = 0;

  function automatic void append_ch(input logic [7:0] c);
    str_q.insert(str_q.size(), c);
  endfunction

  function automatic void expect_chunk(input uchunk_t c);
    unescaped_q.insert(unescaped_q.size(), c);
  endfunction

  function automatic void clear_acc();
    acc     = '0;
    acc_bad = 1'b0;
    ndig    = '0;
  endfunction

  function automatic logic [7:0] unesc(input logic [7:0] c);
    case (c)
      CH_B:    return 8'h08;
      CH_F:    return 8'h0C;
      CH_N:    return 8'h0A;
      CH_R:    return 8'h0D;
      CH_T:    return 8'h09;
      default: return c;
    endcase
  endfunction

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic void put(input logic [7:0] b);
    if (step_n < MAX_PER_REQ) begin
      step_out[step_n] = '{data: b, data_ok: 1'b1, done: 1'b0};
      step_n++;
    end
  endfunction

  function automatic void put_cp(input logic [20:0] cp);
    if (cp < 21'h80) begin
      put(cp[7:0]);
    end else if (cp < 21'h800) begin
      put(8'hC0 | 8'(cp >> 6));
      put(8'h80 | 8'(cp & 21'h3F));
    end else if (cp < 21'h10000) begin
      put(8'hE0 | 8'(cp >> 12));
      put(8'h80 | 8'((cp >> 6) & 21'h3F));
      put(8'h80 | 8'(cp & 21'h3F));
    end else begin
      put(8'hF0 | 8'(cp >> 18));
      put(8'h80 | 8'((cp >> 12) & 21'h3F));
      put(8'h80 | 8'((cp >> 6) & 21'h3F));
      put(8'h80 | 8'(cp & 21'h3F));
    end
  endfunction

  function automatic void take_hex(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= "0" && c <= "9") d = 4'(c - "0");
    else if (c >= "a" && c <= "f") d = 4'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") d = 4'(c - "A" + 8'd10);
    else acc_bad = 1'b1;
    acc = {acc[11:0], d};
  endfunction

  // re-read the held digits as plain escaped text that ends the string
  function automatic void replay_held(input int n);
    int i;
    logic [7:0] c;
    i = 0;
    while (i < n && i < 3) begin
      c = held[i];
      i++;
      if (c != CH_BSLASH) begin
        put(c);
      end else if (i < n) begin
        c = held[i];
        i++;
        if (c != CH_U) put(unesc(c));
      end
    end
  endfunction

  function automatic void unescape_byte(input logic [7:0] b, input logic last);
    logic [1:0] k;
    step_n = 0;
    case (st)
      ST_ESC: begin
        if (b == CH_U) begin
          if (!last) begin
            st = ST_HEX1;
            clear_acc();
          end
        end else begin
          put(unesc(b));
          st = ST_TEXT;
        end
      end
      ST_HEX1, ST_HEX2: begin
        k = ndig[1:0];
        take_hex(b);
        if (k < 2'd3) begin
          held[k] = b;
          ndig = 3'(k) + 3'd1;
          if (last) begin
            if (st == ST_HEX2) put_cp(21'(hi_sur));
            replay_held(int'(k) + 1);
          end
        end else if (st == ST_HEX1) begin
          if (acc_bad) begin
            put(BAD_HEX);
            st = ST_TEXT;
          end else if (acc >= HIGH_MIN && acc <= HIGH_MAX && !last) begin
            hi_sur = acc;
            st = ST_AFTER_HI;
          end else begin
            put_cp(21'(acc));
            st = ST_TEXT;
          end
          ndig = '0;
        end else begin
          if (!acc_bad && acc >= LOW_MIN && acc <= LOW_MAX)
            put_cp(SUPP_BASE + (21'(hi_sur - HIGH_MIN) << 10) + 21'(acc - LOW_MIN));
          else
            put_cp(21'(hi_sur));
          ndig = '0;
          st = ST_TEXT;
        end
      end
      ST_AFTER_HI: begin
        if (b == CH_BSLASH && !last) begin
          st = ST_HI_BSLASH;
        end else begin
          put_cp(21'(hi_sur));
          if (b != CH_BSLASH) put(b);
          st = ST_TEXT;
        end
      end
      ST_HI_BSLASH: begin
        if (b == CH_U && !last) begin
          st = ST_HEX2;
          clear_acc();
        end else begin
          put_cp(21'(hi_sur));
          if (b != CH_U) put(unesc(b));
          st = ST_TEXT;
        end
      end
      default: begin
        st = ST_TEXT;
        if (b == CH_BSLASH) begin
          if (!last) st = ST_ESC;
        end else begin
          put(b);
        end
      end
    endcase
    if (last) begin
      if (step_n == 0) begin
        step_out[0] = '{data: 8'h00, data_ok: 1'b0, done: 1'b1};
        step_n = 1;
      end else begin
        step_out[step_n-1].done = 1'b1;
      end
      st = ST_TEXT;
      clear_acc();
      hi_sur = '0;
    end
  endfunction

  function automatic void flag(input string what, input uchunk_t want, input uchunk_t got);
    n_err++;
    if (n_err <= 10)
      $display("%0t: %s: expected %h/%b/%b, got %h/%b/%b (byte/valid/done)", $time, what,
               want.data, want.data_ok, want.done, got.data, got.data_ok, got.done);
  endfunction

  // stimulus helpers
  function automatic int unsigned pick(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(0, 7))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 4'd10);
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 5))
      0:       return CH_BSLASH;
      1:       return CH_U;
      2, 3:    return hex_char(4'($urandom_range(0, 15)));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_u(input logic [15:0] v);
    append_ch(CH_BSLASH);
    append_ch(CH_U);
    for (int i = 3; i >= 0; i--) append_ch(hex_char(v[4*i +: 4]));
  endfunction

  // strings of random text and escapes, some malformed or cut off, or raw noise biased to escapes
  function automatic void build_string(input bit noisy);
    int k;
    logic [7:0] c;
    logic [7:0] esc_set [8];
    esc_set = '{8'h22, CH_BSLASH, 8'h2F, CH_B, CH_F, CH_N, CH_R, CH_T};
    str_q.delete();
    if (noisy) begin
      repeat ($urandom_range(1, 8)) append_ch(noise_char());
      return;
    end
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          c = 8'($urandom_range(0, 255));
          if (c == CH_BSLASH) append_ch(CH_BSLASH);
          append_ch(c);
        end
        3, 4: begin
          append_ch(CH_BSLASH);
          if ($urandom_range(0, 3) == 0) begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_U);
          end else begin
            c = esc_set[$urandom_range(0, 7)];
          end
          append_ch(c);
        end
        5: push_u(16'($urandom_range(0, 1) ? pick(0, 'h7F) : pick('h80, 'h7FF)));
        6: push_u(16'(pick('h800, 'hFFFF)));
        7: begin
          push_u(16'(pick(HIGH_MIN, HIGH_MAX)));
          push_u(16'(pick(LOW_MIN, LOW_MAX)));
        end
        8: begin
          // high half followed by something other than a low half
          push_u(16'(pick(HIGH_MIN, HIGH_MAX)));
          case ($urandom_range(0, 3))
            0: push_u(16'($urandom_range(0, 1) ? pick(0, 'hDBFF) : pick('hE000, 'hFFFF)));
            1: append_ch(8'($urandom_range(0, 255)));
            2: begin
              append_ch(CH_BSLASH);
              append_ch(noise_char());
            end
            default: ;
          endcase
        end
        default: begin
          push_u(16'($urandom_range(0, 'hFFFF)));
          do c = 8'($urandom_range(0, 255)); while (is_hex(c));
          str_q[str_q.size() - 1 - $urandom_range(0, 3)] = c;
        end
      endcase
    end
    // cut the string off inside an escape now and then
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0: append_ch(CH_BSLASH);
        1: begin
          append_ch(CH_BSLASH);
          append_ch(CH_U);
          repeat ($urandom_range(0, 3)) append_ch(noise_char());
        end
        default: begin
          push_u(16'(pick(HIGH_MIN, HIGH_MAX)));
          k = $urandom_range(0, 5);
          if (k >= 1) append_ch(CH_BSLASH);
          if (k >= 2) append_ch(CH_U);
          if (k >= 3) repeat (k - 2) append_ch(noise_char());
        end
      endcase
    end
  endfunction

  task automatic send_req(input logic [7:0] b, input logic last, input logic typed,
                          input uchunk_t want);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.in_byte       <= b;
    req_if.end_of_string <= last;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    unescape_byte(b, last);
    if (typed) begin
      expect_chunk(want);
    end else begin
      for (int i = 0; i < step_n; i++) expect_chunk(step_out[i]);
    end
    if (last) n_str++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : res_check
    uchunk_t got;
    uchunk_t want;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      got = '{data: res_if.out_byte, data_ok: res_if.byte_valid, done: res_if.string_done};
      n_res++;
      if (unescaped_q.size() == 0) begin
        flag("unexpected result", '0, got);
      end else begin
        want = unescaped_q.pop_front();
        if (got.data !== want.data || got.data_ok !== want.data_ok || got.done !== want.done)
          flag("mismatch", want, got);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off to back the block up
  initial begin : res_ready_drv
    int stall;
    stall = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        stall--;
        res_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES - 1;
        res_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(0, 14);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", unescaped_q.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stim
    int i;
    req_if.valid         = 1'b0;
    req_if.in_byte       = 8'h00;
    req_if.end_of_string = 1'b0;
    st = ST_TEXT;
    clear_acc();
    hi_sur = '0;
    step_n = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    for (i = 0; i < N_DIR; i++)
      send_req(DIR_ROWS[i].b, DIR_ROWS[i].last, DIR_ROWS[i].typed, DIR_ROWS[i].want);

    hold_req = 1'b1;
    while (n_rand < N_RAND) begin
      // drop all idling for the tail of the run
      if (n_rand >= N_RAND - 50) quiet = 1'b1;
      build_string($urandom_range(0, 4) == 0);
      for (i = 0; i < str_q.size(); i++) begin
        send_req(str_q[i], i == str_q.size() - 1, 1'b0, '0);
        n_rand++;
      end
    end
    req_if.valid <= 1'b0;

    while (unescaped_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d directed and %0d random requests in %0d strings; %0d results checked.",
             N_DIR, n_rand, n_str, n_res);
    $display("Included a %0d-cycle receiver hold-off; %0d mismatches.", HOLD_CYCLES, n_err);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
